### sv/sha1_pkg.sv
// Package with the shared types, constants and control structs of the SHA-1 hash block.
`default_nettype none

package sha1_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned IDX_W       = 3;

    localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
    localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_P1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_P2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_P3   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd4;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    localparam logic [WORD_W-1:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [IDX_W-1:0]  word_index;
        logic              last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      shift_en;
        t_byte_sel sel;
        logic      count_en;
        logic      count_clr;
        logic      load_vars;
        logic      round_en;
        logic      add_en;
        logic      h_init;
        logic      idx_next;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_last;
        logic pos_len;
        logic round_last;
        logic idx_last;
    } t_dp_status;

endpackage

`default_nettype wire

### sv/sha1_ctrl.sv
// Controller state machine that sequences loading, padding, rounds and digest output.
`default_nettype none

module sha1_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_has_byte,
    input  logic                   i_last_byte,
    input  logic                   i_out_stall,
    input  sha1_pkg::t_dp_status   i_status,
    output sha1_pkg::t_dp_cmd      o_cmd,
    output logic                   o_in_stall,
    output logic                   o_out_valid
);

    sha1_pkg::t_state r_state, n_state;
    // r_pad: message ended, padding in progress. r_mark: the 0x80 byte is in.
    // r_final: the length goes into the block now being filled.
    logic r_pad, n_pad;
    logic r_mark, n_mark;
    logic r_final, n_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1_pkg::ST_IDLE;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_mark  <= n_mark;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pad   = r_pad;
        n_mark  = r_mark;
        n_final = r_final;
        unique case (r_state)
            sha1_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_has_byte && i_status.pos_last) begin
                        n_state = sha1_pkg::ST_ROUND;
                        n_pad   = i_last_byte;
                    end else if (i_last_byte) begin
                        n_state = sha1_pkg::ST_PAD;
                        n_pad   = 1'b1;
                    end
                end
            end
            sha1_pkg::ST_PAD: begin
                if (!r_mark) begin
                    n_mark  = 1'b1;
                    n_final = !i_status.pos_len;
                end
                if (i_status.pos_last) begin
                    n_state = sha1_pkg::ST_ROUND;
                end
            end
            sha1_pkg::ST_ROUND: begin
                if (i_status.round_last) begin
                    n_state = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD: begin
                if (r_pad && r_final) begin
                    n_state = sha1_pkg::ST_EMIT;
                end else if (r_pad) begin
                    n_state = sha1_pkg::ST_PAD;
                    n_final = 1'b1;
                end else begin
                    n_state = sha1_pkg::ST_IDLE;
                end
            end
            sha1_pkg::ST_EMIT: begin
                if (!i_out_stall && i_status.idx_last) begin
                    n_state = sha1_pkg::ST_IDLE;
                    n_pad   = 1'b0;
                    n_mark  = 1'b0;
                    n_final = 1'b0;
                end
            end
            default: begin
                n_state = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.sel   = sha1_pkg::SEL_ZERO;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            sha1_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_has_byte) begin
                    o_cmd.shift_en  = 1'b1;
                    o_cmd.sel       = sha1_pkg::SEL_MSG;
                    o_cmd.count_en  = 1'b1;
                    o_cmd.load_vars = i_status.pos_last;
                end
            end
            sha1_pkg::ST_PAD: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.load_vars = i_status.pos_last;
                if (!r_mark) begin
                    o_cmd.sel = sha1_pkg::SEL_MARK;
                end else if (r_final && i_status.pos_len) begin
                    o_cmd.sel = sha1_pkg::SEL_LEN;
                end else begin
                    o_cmd.sel = sha1_pkg::SEL_ZERO;
                end
            end
            sha1_pkg::ST_ROUND: begin
                o_cmd.round_en = 1'b1;
            end
            sha1_pkg::ST_ADD: begin
                o_cmd.add_en = 1'b1;
            end
            sha1_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.idx_next = 1'b1;
                    if (i_status.idx_last) begin
                        o_cmd.h_init    = 1'b1;
                        o_cmd.count_clr = 1'b1;
                    end
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/sha1_dp.sv
// Datapath with the block window, message schedule, round logic, chaining words and counters.
`default_nettype none

module sha1_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sha1_pkg::t_dp_cmd                   i_cmd,
    input  logic [sha1_pkg::BYTE_W-1:0]         i_byte,
    output sha1_pkg::t_dp_status                o_status,
    output sha1_pkg::t_out_item                 o_item
);

    localparam int unsigned BW = sha1_pkg::BYTE_W;
    localparam int unsigned WW = sha1_pkg::WORD_W;
    localparam int unsigned NB = sha1_pkg::BLOCK_WORDS;
    localparam int unsigned NH = sha1_pkg::HASH_WORDS;

    // r_win[0] is the oldest word; bytes enter at the low end of r_win[15].
    // During rounds r_win[0] holds the schedule word of the current round.
    logic [WW-1:0] r_win [NB];
    logic [WW-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [WW-1:0] r_h [NH];
    logic [sha1_pkg::COUNT_W-1:0] r_count;
    logic [sha1_pkg::POS_W-1:0]   r_pos;
    logic [sha1_pkg::ROUND_W-1:0] r_round;
    logic [sha1_pkg::IDX_W-1:0]   r_idx;

    logic [BW-1:0]   shift_byte;
    logic [63:0]     len_bits;
    logic [63:0]     len_shift;
    logic [WW-1:0]   w_mix;
    logic [WW-1:0]   w_new;
    logic [WW-1:0]   f_val;
    logic [WW-1:0]   k_val;
    logic [WW-1:0]   t_sum;

    assign len_bits  = {r_count, 3'b000};
    assign len_shift = len_bits << {r_pos[2:0], 3'b000};

    always_comb begin
        unique case (i_cmd.sel)
            sha1_pkg::SEL_MSG:  shift_byte = i_byte;
            sha1_pkg::SEL_MARK: shift_byte = sha1_pkg::PAD_MARK;
            sha1_pkg::SEL_ZERO: shift_byte = '0;
            sha1_pkg::SEL_LEN:  shift_byte = len_shift[63 -: BW];
            default:            shift_byte = '0;
        endcase
    end

    assign w_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign w_new = {w_mix[WW-2:0], w_mix[WW-1]};

    always_comb begin
        if (r_round < sha1_pkg::ROUND_P1) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1_pkg::K_0;
        end else if (r_round < sha1_pkg::ROUND_P2) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K_1;
        end else if (r_round < sha1_pkg::ROUND_P3) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1_pkg::K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1_pkg::K_3;
        end
    end

    assign t_sum = {r_a[WW-6:0], r_a[WW-1 -: 5]} + f_val + r_e + k_val + r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            for (int i = 0; i < NB - 1; i++) begin
                r_win[i] <= {r_win[i][WW-BW-1:0], r_win[i+1][WW-1 -: BW]};
            end
            r_win[NB-1] <= {r_win[NB-1][WW-BW-1:0], shift_byte};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < NB - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[NB-1] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[WW-1:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NH; i++) begin
                r_h[i] <= sha1_pkg::H_INIT[i];
            end
            r_count <= '0;
            r_pos   <= '0;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.h_init) begin
                for (int i = 0; i < NH; i++) begin
                    r_h[i] <= sha1_pkg::H_INIT[i];
                end
            end else if (i_cmd.add_en) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.count_en) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.shift_en) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.load_vars) begin
                r_round <= '0;
            end else if (i_cmd.round_en) begin
                r_round <= r_round + 1'b1;
            end
            if (i_cmd.idx_next) begin
                r_idx <= (r_idx == sha1_pkg::IDX_LAST) ? '0 : r_idx + 1'b1;
            end
        end
    end

    assign o_status.pos_last   = (r_pos == sha1_pkg::POS_LAST);
    assign o_status.pos_len    = (r_pos >= sha1_pkg::POS_LEN);
    assign o_status.round_last = (r_round == sha1_pkg::ROUND_LAST);
    assign o_status.idx_last   = (r_idx == sha1_pkg::IDX_LAST);

    assign o_item.digest_word = r_h[r_idx];
    assign o_item.word_index  = r_idx;
    assign o_item.last_word   = (r_idx == sha1_pkg::IDX_LAST);

endmodule

`default_nettype wire

### sv/sha1_message_hash.sv
// Top level of the streaming SHA-1 hash block: controller plus datapath.
//
// The input channel takes one beat per message byte (data_byte, has_byte,
// last_byte). A beat with has_byte set adds its byte to the message; a beat
// with last_byte set ends the message after its byte, if any. A beat with
// neither flag does nothing. The output channel gives five beats per message,
// digest words H0 to H4 in order, with last_word set on the fifth.
// Message bytes are taken while o_in_stall is low. Every 64th byte starts
// the compression, which holds o_in_stall high through the rounds and the
// fold of the round result into the chaining words; a single shared round
// unit runs all the rounds.
// After the last beat the block shifts in the padding one byte per cycle up
// to the end of the block, followed by one compression, or by two when fewer
// than nine bytes were free, and then by the digest beats, which come
// straight from the chaining registers.
// If the receiver raises i_out_stall the current word simply holds, and the
// block accepts no new input until the fifth word is taken; it then returns
// to its initial chaining values and a zero byte count for the next message.
// Reset, synchronous and active low, gives that same initial state at once.
`default_nettype none

module sha1_message_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sha1_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sha1_pkg::t_out_item o_out_data
);

    sha1_pkg::t_dp_cmd    dp_cmd;
    sha1_pkg::t_dp_status dp_status;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_has_byte  (i_in_data.has_byte),
        .i_last_byte (i_in_data.last_byte),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    sha1_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_byte   (i_in_data.data_byte),
        .o_status (dp_status),
        .o_item   (o_out_data)
    );

endmodule

`default_nettype wire
